// ===== design/normal_cdf_approx_top_defines.svh =====
// assertion macros used by the normal cdf top level
`ifndef NORMAL_CDF_APPROX_TOP_DEFINES_SVH
`define NORMAL_CDF_APPROX_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define NCDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define NCDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ncdf_pkg.sv =====
// types, formats and polynomial coefficients for the normal cdf pipeline
package ncdf_pkg;

  // fixed point constants: Q_ONE in Q.30, P_ONE and P_HALF in q1.16, limits and MAG_TWO on the q3.12 z scale
  localparam logic [30:0] Q_ONE    = 31'h4000_0000;
  localparam logic [16:0] P_ONE    = 17'h1_0000;
  localparam logic [16:0] P_HALF   = 17'h0_8000;
  localparam logic [15:0] LIM_SMALL = 16'd8192;
  localparam logic [15:0] LIM_SAT   = 16'd24576;
  localparam logic [16:0] MAG_TWO   = 17'd16384;

  // decimal coefficient scaled by 1e-12 to Q.30: n * 2^18 / 5^12, rounded
  localparam logic [63:0] Q_MUL = 64'd262144;
  localparam logic [63:0] Q_RND = 64'd122070312;
  localparam logic [63:0] Q_DEN = 64'd244140625;

  // pipeline shape
  localparam int NUM_SMALL   = 9;
  localparam int NUM_LARGE   = 15;
  localparam int NUM_STEPS   = NUM_LARGE - 1;
  localparam int SMALL_FIRST = NUM_STEPS - NUM_SMALL + 1;
  localparam int STEP_STAGES = 4;
  localparam int LATENCY     = 3 + STEP_STAGES * (NUM_STEPS + 1);

  // operand choice of one multiply-add step for items on the small branch
  typedef enum logic [1:0] {
    OP_SQR,
    OP_PASS,
    OP_W,
    OP_Y
  } op_e;

  // per-item data carried down the pipeline
  typedef struct packed {
    logic               is_small;
    logic               pos;
    logic               sat;
    logic [29:0]        ymag;
    logic [30:0]        w;
    logic [30:0]        vmag;
    logic               vneg;
    logic signed [31:0] acc;
  } pipe_t;

  function automatic logic signed [31:0] qc(input logic [63:0] n, input logic neg);
    logic [63:0] m;
    m = (n * Q_MUL + Q_RND) / Q_DEN;
    return neg ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

  // odd polynomial in y squared, highest power first
  localparam logic signed [31:0] POLY_SMALL [NUM_SMALL] = '{
    qc(64'd124818987,    1'b0), qc(64'd1075204047,   1'b1),
    qc(64'd5198775019,   1'b0), qc(64'd19198292004,  1'b1),
    qc(64'd59054035642,  1'b0), qc(64'd151968751364, 1'b1),
    qc(64'd319152932694, 1'b0), qc(64'd531923007300, 1'b1),
    qc(64'd797884560593, 1'b0)
  };

  // polynomial in y minus 2, highest power first
  localparam logic signed [31:0] POLY_LARGE [NUM_LARGE] = '{
    qc(64'd45255659,     1'b1), qc(64'd152529290,    1'b0),
    qc(64'd19538132,     1'b1), qc(64'd676904986,    1'b1),
    qc(64'd1390604284,   1'b0), qc(64'd794620820,    1'b1),
    qc(64'd2034254874,   1'b1), qc(64'd6549791214,   1'b0),
    qc(64'd10557625006,  1'b1), qc(64'd11630447319,  1'b0),
    qc(64'd9279453341,   1'b1), qc(64'd5353579108,   1'b0),
    qc(64'd2141268741,   1'b1), qc(64'd535310849,    1'b0),
    qc(64'd999936657524, 1'b0)
  };

endpackage

// ===== design/ncdf_step.sv =====
// one horner step: rounded q.30 multiply then coefficient add, four stages
module ncdf_step import ncdf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  op_e                op_i,
  input  logic signed [31:0] coef_small_i,
  input  logic signed [31:0] coef_large_i,
  input  logic               valid_i,
  input  pipe_t              pipe_i,
  output logic               valid_o,
  output pipe_t              pipe_o
);

  typedef struct packed {
    logic               neg;
    logic               pass;
    logic               to_w;
    logic signed [31:0] coef;
  } ctl_t;

  logic        acc_neg;
  logic [31:0] acc_mag;
  logic [31:0] amag_d, amag_q;
  logic [30:0] bmag_d, bmag_q;
  ctl_t        ctl_d, ctl_a_q, ctl_b_q, ctl_c_q;
  pipe_t       pipe_a_q, pipe_b_q, pipe_c_q, pipe_d, pipe_d_q;
  logic [62:0] prod_d, prod_q;
  logic [63:0] rsum;
  logic [33:0] rnd_d, rnd_q;
  logic [34:0] sum_d;
  logic        vld_a_q, vld_b_q, vld_c_q, vld_d_q;

  // stage a: operand select and sign-magnitude split
  always_comb begin
    acc_neg = pipe_i.acc[31];
    acc_mag = acc_neg ? (~pipe_i.acc + 32'd1) : pipe_i.acc;
    amag_d  = acc_mag;
    bmag_d  = pipe_i.vmag;
    ctl_d   = '0;
    ctl_d.neg  = acc_neg ^ pipe_i.vneg;
    ctl_d.coef = coef_large_i;
    if (op_i == OP_SQR) begin
      amag_d     = {2'b00, pipe_i.ymag};
      bmag_d     = {1'b0, pipe_i.ymag};
      ctl_d.neg  = 1'b0;
      ctl_d.coef = '0;
      ctl_d.to_w = 1'b1;
    end else if (pipe_i.is_small) begin
      ctl_d.neg  = acc_neg;
      ctl_d.coef = coef_small_i;
      unique case (op_i)
        OP_W:    bmag_d = pipe_i.w;
        OP_Y:    bmag_d = {1'b0, pipe_i.ymag};
        default: ctl_d.pass = 1'b1;
      endcase
    end
  end

  // stage b: magnitude product
  assign prod_d = 63'(amag_q) * 63'(bmag_q);

  // stage c: round half away from zero on the magnitude
  assign rsum  = {1'b0, prod_q} + 64'h2000_0000;
  assign rnd_d = rsum[63:30];

  // stage d: apply sign and add the coefficient
  always_comb begin
    sum_d = ctl_c_q.neg ? ({{3{ctl_c_q.coef[31]}}, ctl_c_q.coef} - {1'b0, rnd_q})
                        : ({{3{ctl_c_q.coef[31]}}, ctl_c_q.coef} + {1'b0, rnd_q});
    pipe_d = pipe_c_q;
    if (ctl_c_q.to_w) begin
      pipe_d.w = sum_d[30:0];
    end else if (!ctl_c_q.pass) begin
      pipe_d.acc = $signed(sum_d[31:0]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      vld_d_q <= vld_c_q;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    pipe_a_q <= pipe_i;
    ctl_a_q  <= ctl_d;
    amag_q   <= amag_d;
    bmag_q   <= bmag_d;
    pipe_b_q <= pipe_a_q;
    ctl_b_q  <= ctl_a_q;
    prod_q   <= prod_d;
    pipe_c_q <= pipe_b_q;
    ctl_c_q  <= ctl_b_q;
    rnd_q    <= rnd_d;
    pipe_d_q <= pipe_d;
  end

  assign valid_o = vld_d_q;
  assign pipe_o  = pipe_d_q;

endmodule

// ===== design/normal_cdf_approx_top.sv =====
// normal cdf of a q3.12 z-score as unsigned q1.16, fully pipelined
//
// One request is taken in every clock cycle: busy is never raised, and a
// request is accepted whenever start is high. Each result shows on
// probability_o for one cycle with done_o high, in request order; there is
// no back-pressure, so the receiver must take every result when it appears.
// The pipeline is the chain of 15 multiply-add steps (one squaring and 14
// horner steps), four register stages each, plus an input decode stage and
// two output stages for the clamp and the final rounding.
`include "normal_cdf_approx_top_defines.svh"

module normal_cdf_approx_top import ncdf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] z_score_i,
  output logic               done_o,
  output logic [16:0]        probability_o
);

  logic        in_neg;
  logic [15:0] in_mag;
  logic [16:0] dev;
  logic [16:0] dev_abs;
  pipe_t       s0_d, s0_q;
  logic        s0_vld_q;

  pipe_t       chain_pipe [NUM_STEPS + 2];
  logic        chain_vld  [NUM_STEPS + 2];

  pipe_t       last;
  logic signed [32:0] x_full;
  logic [30:0] xc_d, xc_q;
  logic        f1_vld_q, f1_pos_q, f1_sat_q;
  logic [31:0] pv;
  logic [31:0] prnd;
  logic [16:0] prob_d, prob_q;
  logic        done_q;

  // the pipeline never holds requests off
  assign busy = 1'b0;

  // decode: magnitude, branch and operands
  always_comb begin
    in_neg  = z_score_i[15];
    in_mag  = in_neg ? (~z_score_i + 16'd1) : z_score_i;
    dev     = {1'b0, in_mag} - MAG_TWO;
    dev_abs = dev[16] ? (~dev + 17'd1) : dev;
    s0_d          = '0;
    s0_d.pos      = !in_neg && (z_score_i != '0);
    s0_d.sat      = in_mag > LIM_SAT;
    s0_d.is_small = in_mag < LIM_SMALL;
    s0_d.ymag     = {in_mag[12:0], 17'b0};
    s0_d.vmag     = {dev_abs[13:0], 17'b0};
    s0_d.vneg     = dev[16];
    s0_d.w        = '0;
    s0_d.acc      = s0_d.is_small ? POLY_SMALL[0] : POLY_LARGE[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
  end

  assign chain_pipe[0] = s0_q;
  assign chain_vld[0]  = s0_vld_q;

  // squaring step: w = y * y for the small branch
  ncdf_step u_sqr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (OP_SQR),
    .coef_small_i ('0),
    .coef_large_i ('0),
    .valid_i      (chain_vld[0]),
    .pipe_i       (chain_pipe[0]),
    .valid_o      (chain_vld[1]),
    .pipe_o       (chain_pipe[1])
  );

  // horner steps; the small branch idles through the first ones
  for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
    if (k < SMALL_FIRST) begin : g_pass
      ncdf_step u_step (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .op_i         (OP_PASS),
        .coef_small_i ('0),
        .coef_large_i (POLY_LARGE[k]),
        .valid_i      (chain_vld[k]),
        .pipe_i       (chain_pipe[k]),
        .valid_o      (chain_vld[k + 1]),
        .pipe_o       (chain_pipe[k + 1])
      );
    end else if (k < NUM_STEPS) begin : g_w
      ncdf_step u_step (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .op_i         (OP_W),
        .coef_small_i (POLY_SMALL[k - SMALL_FIRST + 1]),
        .coef_large_i (POLY_LARGE[k]),
        .valid_i      (chain_vld[k]),
        .pipe_i       (chain_pipe[k]),
        .valid_o      (chain_vld[k + 1]),
        .pipe_o       (chain_pipe[k + 1])
      );
    end else begin : g_y
      ncdf_step u_step (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .op_i         (OP_Y),
        .coef_small_i ('0),
        .coef_large_i (POLY_LARGE[k]),
        .valid_i      (chain_vld[k]),
        .pipe_i       (chain_pipe[k]),
        .valid_o      (chain_vld[k + 1]),
        .pipe_o       (chain_pipe[k + 1])
      );
    end
  end

  assign last = chain_pipe[NUM_STEPS + 1];

  // clamp x to [0, 1]; small branch doubles the odd polynomial
  always_comb begin
    x_full = last.is_small ? {last.acc, 1'b0} : {last.acc[31], last.acc};
    if (x_full[32]) begin
      xc_d = '0;
    end else if (x_full[31:0] > {1'b0, Q_ONE}) begin
      xc_d = Q_ONE;
    end else begin
      xc_d = x_full[30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      f1_vld_q <= chain_vld[NUM_STEPS + 1];
      done_q   <= f1_vld_q;
    end
  end

  // symmetry, round to q1.16, saturation
  always_comb begin
    pv   = f1_pos_q ? ({1'b0, Q_ONE} + {1'b0, xc_q}) : ({1'b0, Q_ONE} - {1'b0, xc_q});
    prnd = pv + 32'h0000_4000;
    prob_d = prnd[31:15];
    if (f1_sat_q) begin
      prob_d = f1_pos_q ? P_ONE : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    xc_q     <= xc_d;
    f1_pos_q <= last.pos;
    f1_sat_q <= last.sat;
    prob_q   <= prob_d;
  end

  assign done_o        = done_q;
  assign probability_o = prob_q;

  // checks
  `NCDF_ASSERT_IMP(a_lat, start && !busy, ##LATENCY done_o, "request without result")
  `NCDF_ASSERT_IMP(a_src, done_o, $past(start && !busy, LATENCY), "result without request")
  `NCDF_ASSERT_IMP(a_zero, start && !busy && z_score_i == 16'sd0,
                   ##LATENCY probability_o == P_HALF, "zero z not one half")
  `NCDF_ASSERT_IMP(a_range, done_o, probability_o <= P_ONE, "probability above one")
  `NCDF_ASSERT_NXT(a_sat, f1_vld_q && f1_sat_q,
                   probability_o == P_ONE || probability_o == '0, "saturation not 0 or 1")

endmodule
